>>> sv/hpq_pkg.sv
package hpq_pkg;

  // Width of the occupancy field on the result channel
  localparam int OCC_BITS = 7;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_FIN,
    S_POP_LD,
    S_DN,
    S_DONE
  } state_t;

endpackage

>>> sv/hpq_if.sv
// Request channel: push or pop
interface hpq_in_if #(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 8
);
  logic                  valid;
  logic                  ready;
  hpq_pkg::op_t          operation;
  logic [KEY_BITS-1:0]   entry_key;
  logic [TAG_BITS-1:0]   entry_tag;

  modport source (output valid, operation, entry_key, entry_tag, input ready);
  modport sink   (input valid, operation, entry_key, entry_tag, output ready);
endinterface

// Result channel: one result per request
interface hpq_out_if #(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 8
);
  logic                          valid;
  logic                          ready;
  hpq_pkg::status_t              status;
  logic [KEY_BITS-1:0]           out_key;
  logic [TAG_BITS-1:0]           out_tag;
  logic [hpq_pkg::OCC_BITS-1:0]  occupancy;

  modport source (output valid, status, out_key, out_tag, occupancy, input ready);
  modport sink   (input valid, status, out_key, out_tag, occupancy, output ready);
endinterface

>>> sv/binary_heap_priority_queue.sv
// Binary heap priority queue of CAPACITY entries (key, tag). A request is a push or a
// pop and gets exactly one result on out_ch; cfg_wdata written with cfg_we picks
// smallest-key-first (0, reset) or largest-key-first (1). Equal keys never swap.
// The heap lives in one RAM with two registered read ports and one write port; the
// moving entry is held in a register and only the hole walks the tree, so each tree
// level is a read, a compare and a write back. A push climbs the tree level by level,
// and a pop first loads the root and the last entry, then sinks; both then load the
// result register. A refused push, a pop on empty, a push into an empty heap and a
// pop of the last entry skip the walk, and a finished request may wait on out_ch
// until the result register is free.
// A new request is taken as soon as the previous one has been handed to the result
// register, even if that result has not been taken yet. No clearing pass is needed
// after reset: only slots below the entry count are ever used.
module binary_heap_priority_queue #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  hpq_in_if.sink     in_ch,
  hpq_out_if.source  out_ch
);

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int POS_BITS = IDX_BITS + 2;
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(CAPACITY);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  function automatic logic beats(input logic mode, input logic [KEY_BITS-1:0] a,
                                 input logic [KEY_BITS-1:0] b);
    return mode ? (a > b) : (a < b);
  endfunction

  // Heap storage
  entry_t heap_mem [CAPACITY];
  entry_t rd_a_q, rd_b_q;
  logic                wr_en;
  logic [IDX_BITS-1:0] wr_addr;
  entry_t              wr_data;
  logic [IDX_BITS-1:0] rd_a_addr, rd_b_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  // Control and datapath registers
  hpq_pkg::state_t     state_r, state_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [IDX_BITS-1:0] hole_r, hole_nxt;
  entry_t              mov_r, mov_nxt;
  logic                order_r;
  hpq_pkg::status_t    res_status_r, res_status_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;

  hpq_pkg::status_t             out_status_r;
  logic [KEY_BITS-1:0]          out_key_r;
  logic [TAG_BITS-1:0]          out_tag_r;
  logic [hpq_pkg::OCC_BITS-1:0] out_occ_r;

  // Walk helpers
  logic [CNT_BITS-1:0] cnt_m1;
  logic [IDX_BITS-1:0] par_idx, hole_m1, par_m1;
  logic [POS_BITS-1:0] left_pos, right_pos, cnt_pos, child_pos;
  logic                left_ok, right_ok, take_left, take_right;
  entry_t              child_ent;
  logic [IDX_BITS-1:0] child_idx;

  always_comb begin
    cnt_m1    = count_r - CNT_BITS'(1);
    hole_m1   = hole_r - IDX_BITS'(1);
    par_idx   = hole_m1 >> 1;
    par_m1    = par_idx - IDX_BITS'(1);
    left_pos  = POS_BITS'({hole_r, 1'b1});
    right_pos = left_pos + POS_BITS'(1);
    cnt_pos   = POS_BITS'(count_r);
    left_ok   = left_pos < cnt_pos;
    right_ok  = right_pos < cnt_pos;
    // Right child wins only when strictly better than the current best
    take_left  = left_ok && beats(order_r, rd_a_q.key, mov_r.key);
    take_right = right_ok &&
                 (take_left ? beats(order_r, rd_b_q.key, rd_a_q.key)
                            : beats(order_r, rd_b_q.key, mov_r.key));
    child_ent = take_right ? rd_b_q : rd_a_q;
    child_pos = take_right ? right_pos : left_pos;
    child_idx = child_pos[IDX_BITS-1:0];
  end

  // Sequencer; a write may hit a slot read in the same cycle only where that read data goes unused
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    hole_nxt       = hole_r;
    mov_nxt        = mov_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    wr_en          = 1'b0;
    wr_addr        = hole_r;
    wr_data        = mov_r;
    rd_a_addr      = '0;
    rd_b_addr      = '0;
    out_load       = 1'b0;
    in_ch.ready    = (state_r == hpq_pkg::S_IDLE);

    case (state_r)
      hpq_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          res_key_nxt = '0;
          res_tag_nxt = '0;
          if (in_ch.operation == hpq_pkg::OP_PUSH) begin
            if (count_r == CNT_FULL) begin
              res_status_nxt = hpq_pkg::ST_FULL;
              state_nxt      = hpq_pkg::S_DONE;
            end else begin
              res_status_nxt = hpq_pkg::ST_PUSHED;
              mov_nxt        = '{key: in_ch.entry_key, tag: in_ch.entry_tag};
              hole_nxt       = count_r[IDX_BITS-1:0];
              count_nxt      = count_r + CNT_BITS'(1);
              if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = '{key: in_ch.entry_key, tag: in_ch.entry_tag};
                state_nxt = hpq_pkg::S_DONE;
              end else begin
                rd_a_addr = IDX_BITS'(cnt_m1 >> 1);
                state_nxt = hpq_pkg::S_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = hpq_pkg::ST_EMPTY;
              state_nxt      = hpq_pkg::S_DONE;
            end else begin
              res_status_nxt = hpq_pkg::ST_POPPED;
              rd_a_addr      = '0;
              rd_b_addr      = IDX_BITS'(cnt_m1);
              count_nxt      = cnt_m1;
              hole_nxt       = '0;
              state_nxt      = hpq_pkg::S_POP_LD;
            end
          end
        end
      end

      // Sift up: parent data arrives in rd_a_q
      hpq_pkg::S_UP: begin
        wr_en = 1'b1;
        if (beats(order_r, mov_r.key, rd_a_q.key)) begin
          wr_data  = rd_a_q;
          hole_nxt = par_idx;
          if (par_idx == '0) begin
            state_nxt = hpq_pkg::S_UP_FIN;
          end else begin
            rd_a_addr = par_m1 >> 1;
          end
        end else begin
          state_nxt = hpq_pkg::S_DONE;
        end
      end

      hpq_pkg::S_UP_FIN: begin
        wr_en     = 1'b1;
        state_nxt = hpq_pkg::S_DONE;
      end

      // Root and last entry arrive; start the walk down unless the heap is now empty
      hpq_pkg::S_POP_LD: begin
        res_key_nxt = rd_a_q.key;
        res_tag_nxt = rd_a_q.tag;
        mov_nxt     = rd_b_q;
        if (count_r == '0) begin
          state_nxt = hpq_pkg::S_DONE;
        end else begin
          rd_a_addr = IDX_BITS'(1);
          rd_b_addr = IDX_BITS'(2);
          state_nxt = hpq_pkg::S_DN;
        end
      end

      // Sift down: children arrive in rd_a_q and rd_b_q
      hpq_pkg::S_DN: begin
        wr_en = 1'b1;
        if (take_left || take_right) begin
          wr_data   = child_ent;
          hole_nxt  = child_idx;
          rd_a_addr = IDX_BITS'({child_idx, 1'b1});
          rd_b_addr = IDX_BITS'({child_idx, 1'b1}) + IDX_BITS'(1);
        end else begin
          state_nxt = hpq_pkg::S_DONE;
        end
      end

      hpq_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = hpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = hpq_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpq_pkg::S_IDLE;
      count_r     <= '0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hole_r       <= hole_nxt;
    mov_r        <= mov_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_tag_r    <= res_tag_r;
      out_occ_r    <= hpq_pkg::OCC_BITS'(count_r);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_key   = out_key_r;
  assign out_ch.out_tag   = out_tag_r;
  assign out_ch.occupancy = out_occ_r;

endmodule

>>> sv/hpq_check.sv
module hpq_check #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 8
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input hpq_pkg::status_t             status,
  input logic [KEY_BITS-1:0]          out_key,
  input logic [TAG_BITS-1:0]          out_tag,
  input logic [hpq_pkg::OCC_BITS-1:0] occupancy
);

  localparam logic [hpq_pkg::OCC_BITS-1:0] OCC_FULL = hpq_pkg::OCC_BITS'(CAPACITY);

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one still in work");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // Only a pop returns an entry
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != hpq_pkg::ST_POPPED) |-> (out_key == '0 && out_tag == '0))
    else $error("nonzero key or tag on a non-pop result");

  // Pop on empty reports an empty heap
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == hpq_pkg::ST_EMPTY) |-> (occupancy == '0))
    else $error("pop on empty with nonzero occupancy");

  // Refused push reports a full heap
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == hpq_pkg::ST_FULL) |-> (occupancy == OCC_FULL))
    else $error("refused push while heap not full");

endmodule

bind binary_heap_priority_queue hpq_check #(
  .CAPACITY (CAPACITY),
  .KEY_BITS (KEY_BITS),
  .TAG_BITS (TAG_BITS)
) u_hpq_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .out_key   (out_ch.out_key),
  .out_tag   (out_ch.out_tag),
  .occupancy (out_ch.occupancy)
);
